[hdl/fmva_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmva_pkg
// Shared types and constants of the FM voice allocator.
// ----------------------------------------------------------------------------
package fmva_pkg;

  localparam int NVOICES    = 18;
  localparam int CHANNELS   = 16;
  localparam int MAX_EVENTS = 22;

  localparam logic [3:0] DRUM_CH   = 4'd9;
  localparam logic [6:0] HOLD_THR  = 7'd64;
  localparam logic [4:0] LAST_V    = 5'd17;
  localparam logic [4:0] LAST_NARROW_V = 5'd15;
  localparam logic [4:0] WIDE_V0   = 5'd16;

  typedef enum logic [2:0] {
    ACT_NOTE_ON   = 3'd0,
    ACT_NOTE_OFF  = 3'd1,
    ACT_SUSTAIN   = 3'd2,
    ACT_SOUND_OFF = 3'd3,
    ACT_NOTES_OFF = 3'd4,
    ACT_RESET_CTL = 3'd5
  } action_t;

  typedef enum logic [1:0] {
    PAIR_SINGLE   = 2'd0,
    PAIR_OPTIONAL = 2'd1,
    PAIR_DOUBLE   = 2'd2,
    PAIR_NONE     = 2'd3
  } pair_t;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_FIND   = 10'b0000000100,
    S_STEAL  = 10'b0000001000,
    S_KOFF   = 10'b0000010000,
    S_SETUP1 = 10'b0000100000,
    S_SETUP2 = 10'b0001000000,
    S_EMIT1  = 10'b0010000000,
    S_EMIT2  = 10'b0100000000,
    S_FLUSH  = 10'b1000000000
  } state_t;

endpackage
`default_nettype wire

[hdl/fm_voice_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fm_voice_allocator_unit
// 18-voice allocator: keys voices on and off for channel events, picking
// the longest-idle free voice or stealing by secondary mark, priority, age.
// ----------------------------------------------------------------------------
//  channel | ports                           | moves
//  input   | in_tvalid/in_tready/in_tdata/   | one channel event
//          | in_tuser                        |
//  result  | out_tvalid/out_tready/out_tdata/| one key event, tlast on final
//          | out_tuser/out_tlast             |
//
//  One voice per cycle, unless the output stalls, through a single age/compare
//  unit under a sequencer. Off-type events walk every voice; note-on walks all
//  voices for the free search, then at most two steals, then set-up and key-on.
//  in_tready is high only in idle; a full output register stalls the walk.
//  Synchronous active-low reset clears all voice state and the stamp counter.
// ----------------------------------------------------------------------------
module fm_voice_allocator_unit #(
  parameter int STAMP_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // channel[3:0], note[10:4], pedal_value[17:11], pair_mode[19:18],
  // wide_ok_first[20], wide_ok_second[21], zero[23:22]
  input  wire logic [23:0] in_tdata,
  // action[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // voice[4:0], zero[7:5]
  output logic [7:0]       out_tdata,
  // key_on[0]
  output logic             out_tuser,
  output logic             out_tlast
);

  localparam int NV = fmva_pkg::NVOICES;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  // voice file
  logic [NV-1:0] vact_r, vsus_r, vsec_r;
  logic [3:0]    vch_r   [NV];
  logic [6:0]    vnote_r [NV];
  stamp_t        vstamp_r[NV];
  stamp_t        stamp_r;
  logic [fmva_pkg::CHANNELS-1:0] hold_r, hold_nxt;

  fmva_pkg::state_t state_r, state_nxt;
  logic [2:0] act_r, act_nxt;
  logic [3:0] ch_r, ch_nxt;
  logic [6:0] note_r, note_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic       w1_r, w1_nxt, w2_r, w2_nxt, hold_at_r, hold_at_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic [4:0] v1_r, v1_nxt, v2_r, v2_nxt, pick_r, pick_nxt, cmp_r, cmp_nxt;
  logic       v1_ok_r, v1_ok_nxt, v2_ok_r, v2_ok_nxt, sec_r, sec_nxt;
  logic       ssel_r, ssel_nxt;
  stamp_t     t1_r, t1_nxt, t2_r, t2_nxt, best_r, best_nxt;

  logic       pend_valid_r, pend_on_r;
  logic [4:0] pend_voice_r;
  logic [4:0] ev_cnt_r;
  logic       out_valid_r, out_on_r, out_last_r;
  logic [4:0] out_voice_r;

  // input unpack
  logic [3:0] in_channel;
  logic [6:0] in_note, in_pedal;
  logic [1:0] in_pair;
  assign in_channel = in_tdata[3:0];
  assign in_note    = in_tdata[10:4];
  assign in_pedal   = in_tdata[17:11];
  assign in_pair    = in_tdata[19:18];

  // shared read port and age/compare unit
  logic [4:0] rd_idx;
  logic       r_act, r_sus, r_sec, chm, nm;
  logic [3:0] r_ch;
  stamp_t     age;
  logic [4:0] chn;

  always_comb begin
    unique case (state_r)
      fmva_pkg::S_KOFF:   rd_idx = pick_r;
      fmva_pkg::S_SETUP1: rd_idx = v1_r;
      fmva_pkg::S_SETUP2: rd_idx = v2_r;
      default:            rd_idx = idx_r;
    endcase
  end

  assign r_act = vact_r[rd_idx];
  assign r_sus = vsus_r[rd_idx];
  assign r_sec = vsec_r[rd_idx];
  assign r_ch  = vch_r[rd_idx];
  assign chm   = (r_ch == ch_r);
  assign nm    = (vnote_r[rd_idx] == note_r);
  assign age   = stamp_r - vstamp_r[rd_idx];
  assign chn   = (r_ch == fmva_pkg::DRUM_CH) ? 5'd1 : ({1'b0, r_ch} + 5'd2);

  logic       emit_req, emit_on, flush, wr_koff, wr_setup, wr_sus, set_sec;
  logic [4:0] emit_voice;
  logic       a2e, special, lo, take, last_idx, out_free, need_out, stall, go;

  assign a2e = (mode_r != fmva_pkg::PAIR_SINGLE) && w2_r;

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    ch_nxt      = ch_r;
    note_nxt    = note_r;
    mode_nxt    = mode_r;
    w1_nxt      = w1_r;
    w2_nxt      = w2_r;
    hold_at_nxt = hold_at_r;
    hold_nxt    = hold_r;
    idx_nxt     = idx_r;
    v1_nxt      = v1_r;
    v2_nxt      = v2_r;
    v1_ok_nxt   = v1_ok_r;
    v2_ok_nxt   = v2_ok_r;
    t1_nxt      = t1_r;
    t2_nxt      = t2_r;
    sec_nxt     = sec_r;
    cmp_nxt     = cmp_r;
    best_nxt    = best_r;
    pick_nxt    = pick_r;
    ssel_nxt    = ssel_r;
    emit_req    = 1'b0;
    emit_on     = 1'b0;
    emit_voice  = idx_r;
    flush       = 1'b0;
    wr_koff     = 1'b0;
    wr_setup    = 1'b0;
    wr_sus      = 1'b0;
    set_sec     = 1'b0;
    special     = idx_r >= fmva_pkg::WIDE_V0;
    lo          = 1'b0;
    take        = 1'b0;
    last_idx    = 1'b0;

    unique case (state_r)
      fmva_pkg::S_IDLE: begin
        if (in_tvalid) begin
          act_nxt     = in_tuser;
          ch_nxt      = in_channel;
          note_nxt    = in_note;
          mode_nxt    = in_pair;
          w1_nxt      = in_tdata[20];
          w2_nxt      = in_tdata[21];
          hold_at_nxt = hold_r[in_channel];
          idx_nxt     = '0;
          v1_ok_nxt   = 1'b0;
          v2_ok_nxt   = 1'b0;
          t1_nxt      = '0;
          t2_nxt      = '0;
          state_nxt   = fmva_pkg::S_SCAN;
          priority case (in_tuser)
            fmva_pkg::ACT_NOTE_ON: begin
              state_nxt = (in_pair == fmva_pkg::PAIR_NONE) ? fmva_pkg::S_FLUSH
                                                           : fmva_pkg::S_FIND;
            end
            fmva_pkg::ACT_SUSTAIN: begin
              hold_nxt[in_channel] = (in_pedal >= fmva_pkg::HOLD_THR);
              if (in_pedal >= fmva_pkg::HOLD_THR) state_nxt = fmva_pkg::S_FLUSH;
            end
            fmva_pkg::ACT_RESET_CTL: hold_nxt[in_channel] = 1'b0;
            fmva_pkg::ACT_NOTE_OFF, fmva_pkg::ACT_SOUND_OFF,
            fmva_pkg::ACT_NOTES_OFF: state_nxt = fmva_pkg::S_SCAN;
            default: state_nxt = fmva_pkg::S_FLUSH;
          endcase
        end
      end

      fmva_pkg::S_SCAN: begin
        priority case (act_r)
          fmva_pkg::ACT_NOTE_OFF:  take = r_act && chm && nm;
          fmva_pkg::ACT_SUSTAIN:   take = r_sus && chm;
          fmva_pkg::ACT_SOUND_OFF: take = r_act && chm;
          fmva_pkg::ACT_NOTES_OFF: take = r_act && chm && !r_sus;
          default:                 take = hold_at_r && r_act && chm && r_sus;
        endcase
        if (take) begin
          if (act_r == fmva_pkg::ACT_NOTE_OFF && hold_at_r) begin
            wr_sus = 1'b1;
          end else begin
            wr_koff  = 1'b1;
            emit_req = 1'b1;
          end
        end
        if (idx_r == fmva_pkg::LAST_V) state_nxt = fmva_pkg::S_FLUSH;
        else idx_nxt = idx_r + 5'd1;
      end

      fmva_pkg::S_FIND: begin
        if (r_act) begin
          if (chm && nm) begin
            wr_koff  = 1'b1;
            emit_req = 1'b1;
          end
        end else begin
          lo = (special && w1_r) || (age < t1_r);
          if (lo) begin
            if (!(special && a2e) && age >= t2_r) begin
              t2_nxt    = age;
              v2_nxt    = idx_r;
              v2_ok_nxt = 1'b1;
            end
          end else begin
            // voice 17 keeps the old second pick when voice 16 led a wide pair
            if (idx_r != fmva_pkg::LAST_V ||
                !(v1_ok_r && v1_r == fmva_pkg::WIDE_V0 && a2e)) begin
              v2_nxt    = v1_r;
              v2_ok_nxt = v1_ok_r;
              t2_nxt    = t1_r;
            end
            t1_nxt    = age;
            v1_nxt    = idx_r;
            v1_ok_nxt = 1'b1;
          end
        end
        if (idx_r == fmva_pkg::LAST_V) begin
          idx_nxt  = '0;
          sec_nxt  = 1'b0;
          cmp_nxt  = '0;
          best_nxt = '0;
          pick_nxt = '0;
          if (!v1_ok_nxt) begin
            ssel_nxt  = 1'b0;
            state_nxt = fmva_pkg::S_STEAL;
          end else if (mode_r == fmva_pkg::PAIR_DOUBLE && !v2_ok_nxt) begin
            ssel_nxt  = 1'b1;
            state_nxt = fmva_pkg::S_STEAL;
          end else begin
            state_nxt = fmva_pkg::S_SETUP1;
          end
        end else begin
          idx_nxt = idx_r + 5'd1;
        end
      end

      fmva_pkg::S_STEAL: begin
        if (sec_r == r_sec) begin
          if (chn <= cmp_r) begin
            take = (chn == cmp_r) && (age > best_r);
          end else begin
            take    = 1'b1;
            cmp_nxt = chn;
          end
        end else if (!sec_r) begin
          take    = 1'b1;
          sec_nxt = 1'b1;
          cmp_nxt = chn;
        end
        if (take) begin
          best_nxt = age;
          pick_nxt = idx_r;
        end
        last_idx = (ssel_r ? w2_r : w1_r) ? (idx_r == fmva_pkg::LAST_V)
                                          : (idx_r == fmva_pkg::LAST_NARROW_V);
        if (last_idx) state_nxt = fmva_pkg::S_KOFF;
        else idx_nxt = idx_r + 5'd1;
      end

      fmva_pkg::S_KOFF: begin
        wr_koff    = 1'b1;
        emit_req   = 1'b1;
        emit_voice = pick_r;
        idx_nxt    = '0;
        sec_nxt    = 1'b0;
        cmp_nxt    = '0;
        best_nxt   = '0;
        pick_nxt   = '0;
        if (!ssel_r) begin
          v1_nxt    = pick_r;
          v1_ok_nxt = 1'b1;
          if (mode_r == fmva_pkg::PAIR_DOUBLE && !v2_ok_r) begin
            ssel_nxt  = 1'b1;
            state_nxt = fmva_pkg::S_STEAL;
          end else begin
            state_nxt = fmva_pkg::S_SETUP1;
          end
        end else begin
          v2_nxt    = pick_r;
          v2_ok_nxt = 1'b1;
          state_nxt = fmva_pkg::S_SETUP1;
        end
      end

      fmva_pkg::S_SETUP1: begin
        wr_setup = 1'b1;
        priority if (mode_r == fmva_pkg::PAIR_DOUBLE) state_nxt = fmva_pkg::S_SETUP2;
        else if (mode_r == fmva_pkg::PAIR_OPTIONAL && v2_ok_r)
          state_nxt = fmva_pkg::S_SETUP2;
        else state_nxt = fmva_pkg::S_EMIT1;
      end

      fmva_pkg::S_SETUP2: begin
        wr_setup   = 1'b1;
        set_sec    = (mode_r == fmva_pkg::PAIR_OPTIONAL);
        emit_req   = set_sec;
        emit_on    = 1'b1;
        emit_voice = v2_r;
        state_nxt  = fmva_pkg::S_EMIT1;
      end

      fmva_pkg::S_EMIT1: begin
        emit_req   = 1'b1;
        emit_on    = 1'b1;
        emit_voice = v1_r;
        state_nxt  = (mode_r == fmva_pkg::PAIR_DOUBLE) ? fmva_pkg::S_EMIT2
                                                        : fmva_pkg::S_FLUSH;
      end

      fmva_pkg::S_EMIT2: begin
        emit_req   = 1'b1;
        emit_on    = 1'b1;
        emit_voice = v2_r;
        state_nxt  = fmva_pkg::S_FLUSH;
      end

      fmva_pkg::S_FLUSH: begin
        flush     = 1'b1;
        state_nxt = fmva_pkg::S_IDLE;
      end

      default: state_nxt = fmva_pkg::S_IDLE;
    endcase
  end

  // one pending item is held back until the next one shows whether it is last
  logic emit_keep;
  assign emit_keep = emit_req && (ev_cnt_r < 5'(fmva_pkg::MAX_EVENTS));
  assign out_free  = !out_valid_r || out_tready;
  assign need_out  = emit_keep || flush;
  assign stall     = need_out && pend_valid_r && !out_free;
  assign go        = !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fmva_pkg::S_IDLE;
      vact_r       <= '0;
      vsus_r       <= '0;
      vsec_r       <= '0;
      stamp_r      <= '0;
      hold_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      ev_cnt_r     <= '0;
      for (int i = 0; i < NV; i++) begin
        vch_r[i]    <= '0;
        vnote_r[i]  <= '0;
        vstamp_r[i] <= '0;
      end
    end else begin
      if (need_out && pend_valid_r && go) begin
        out_valid_r <= 1'b1;
        out_voice_r <= pend_voice_r;
        out_on_r    <= pend_on_r;
        out_last_r  <= flush;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (go) begin
        state_r   <= state_nxt;
        act_r     <= act_nxt;
        ch_r      <= ch_nxt;
        note_r    <= note_nxt;
        mode_r    <= mode_nxt;
        w1_r      <= w1_nxt;
        w2_r      <= w2_nxt;
        hold_at_r <= hold_at_nxt;
        hold_r    <= hold_nxt;
        idx_r     <= idx_nxt;
        v1_r      <= v1_nxt;
        v2_r      <= v2_nxt;
        v1_ok_r   <= v1_ok_nxt;
        v2_ok_r   <= v2_ok_nxt;
        t1_r      <= t1_nxt;
        t2_r      <= t2_nxt;
        sec_r     <= sec_nxt;
        cmp_r     <= cmp_nxt;
        best_r    <= best_nxt;
        pick_r    <= pick_nxt;
        ssel_r    <= ssel_nxt;

        if (state_r == fmva_pkg::S_IDLE && in_tvalid) begin
          ev_cnt_r <= '0;
        end else if (emit_keep) begin
          pend_valid_r <= 1'b1;
          pend_voice_r <= emit_voice;
          pend_on_r    <= emit_on;
          ev_cnt_r     <= ev_cnt_r + 5'd1;
        end else if (flush) begin
          pend_valid_r <= 1'b0;
        end

        if (wr_koff) begin
          vact_r[rd_idx]   <= 1'b0;
          vsus_r[rd_idx]   <= 1'b0;
          vsec_r[rd_idx]   <= 1'b0;
          vstamp_r[rd_idx] <= stamp_r;
          stamp_r          <= stamp_r + STAMP_BITS'(1);
        end else if (wr_setup) begin
          vact_r[rd_idx]   <= 1'b1;
          vsus_r[rd_idx]   <= 1'b0;
          vsec_r[rd_idx]   <= set_sec;
          vch_r[rd_idx]    <= ch_r;
          vnote_r[rd_idx]  <= note_r;
          vstamp_r[rd_idx] <= stamp_r;
          stamp_r          <= stamp_r + STAMP_BITS'(1);
        end else if (wr_sus) begin
          vsus_r[rd_idx] <= 1'b1;
        end
      end
    end
  end

  assign in_tready  = (state_r == fmva_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_voice_r};
  assign out_tuser  = out_on_r;
  assign out_tlast  = out_last_r;

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !pend_valid_r)
    else $error("pending item left over in idle");

  a_ev_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= 5'(fmva_pkg::MAX_EVENTS))
    else $error("event count beyond cap");

  a_voice_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= fmva_pkg::LAST_V)
    else $error("voice number out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= fmva_pkg::LAST_V)
    else $error("scan index out of range");

  a_steal_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (stall && state_r == fmva_pkg::S_KOFF) |=> state_r == fmva_pkg::S_KOFF)
    else $error("steal key-off lost under stall");

endmodule
`default_nettype wire
